FILE: rtl/ndem_pkg.sv
// Shared types, constants and helper functions for the neighbour difference edge map unit.
package ndem_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int HEIGHT_W      = 13;
	localparam int ROW_W         = 12;
	localparam int FWIDTH_W      = 11;
	localparam int THRESH_W      = 8;
	localparam int CHAN_W        = 8;
	localparam int PIX_W         = 3 * CHAN_W;
	localparam int CFG_ADDR_W    = 4;
	localparam int CFG_DATA_W    = 32;
	localparam int OUT_FIFO_DEPTH = 4;

	localparam logic [FWIDTH_W-1:0] RST_FRAME_WIDTH    = 11'd1024;
	localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT   = 13'd768;
	localparam logic [THRESH_W-1:0] RST_EDGE_THRESHOLD = 8'd50;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH    = 2'd0,
		REG_FRAME_HEIGHT   = 2'd1,
		REG_EDGE_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} opcode_t;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic line_end;
		logic frame_end;
		logic left_out;
		logic right_out;
		logic top_out;
		logic bottom_out;
	} win_ctl_t;

	typedef struct packed {
		logic edge_res;
		logic line_end;
		logic frame_end;
	} result_t;

	// true when any channel differs by more than the threshold
	function automatic logic chan_exceeds(pixel_t a, pixel_t b, logic [THRESH_W-1:0] thr);
		logic [CHAN_W-1:0] x;
		logic [CHAN_W-1:0] y;
		logic [CHAN_W-1:0] d;
		logic              hit;
		hit = 1'b0;
		for (int c = 0; c < 3; c++) begin
			x = a[c*CHAN_W +: CHAN_W];
			y = b[c*CHAN_W +: CHAN_W];
			d = (x > y) ? (x - y) : (y - x);
			if (d > thr)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

FILE: rtl/neighbor_difference_edge_map_unit.sv
// Top level of the neighbour difference edge map unit: line stores, 3x3 window, edge test.
//
// Pixels enter on the s_axis channel in raster order (tdata = red, green, blue from bit 0,
// tuser = opcode: 0 pixel, 1 drain tick). One edge bit per pixel leaves on m_axis
// (tdata bit 0 = edge, tlast = last pixel of a line, tuser = last pixel of the frame).
// Results trail the input by one line plus one pixel, so frame_width+1 drain ticks after
// the last pixel flush the frame. Drain ticks before the last pixel are dropped.
// The user must set frame size and threshold over the APB port only while the unit is
// idle; the unit itself does not enforce this. A size write restarts the frame.
// One beat per clock is accepted while s_axis_tready is high. A beat goes through the line
// store read and the window shift; its result is then written to the four-entry output
// queue, and m_axis_tvalid rises at the same edge as that write. The input stalls only
// when results in the queue plus those in flight would overfill it; a stalled receiver
// therefore holds back the input after a few beats and nothing is lost.
// Reset clears counters, window and queue. The line stores are not cleared; no result
// reads an entry not written in the current frame.
module neighbor_difference_edge_map_unit #(
	parameter int MAX_WIDTH = ndem_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ndem_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [ndem_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [ndem_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [ndem_pkg::PIX_W-1:0]          s_axis_tdata,  // red, green, blue
	input  logic                                s_axis_tuser,  // opcode
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata,  // edge_res, zero padding
	output logic                                m_axis_tlast,  // line_end
	output logic                                m_axis_tuser   // frame_end
);
	import ndem_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int FW = $clog2(MAX_WIDTH + 2);
	localparam int QW = $clog2(OUT_FIFO_DEPTH);

	// configuration
	logic [FWIDTH_W-1:0] frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic [THRESH_W-1:0] edge_threshold_q;
	logic                cfg_wr;
	cfg_reg_t            cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= RST_FRAME_WIDTH;
			frame_height_q   <= RST_FRAME_HEIGHT;
			edge_threshold_q <= RST_EDGE_THRESHOLD;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_FRAME_WIDTH:    frame_width_q    <= pwdata[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT:   frame_height_q   <= pwdata[HEIGHT_W-1:0];
				REG_EDGE_THRESHOLD: edge_threshold_q <= pwdata[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_FRAME_WIDTH:    prdata = CFG_DATA_W'(frame_width_q);
			REG_FRAME_HEIGHT:   prdata = CFG_DATA_W'(frame_height_q);
			REG_EDGE_THRESHOLD: prdata = CFG_DATA_W'(edge_threshold_q);
			default:            prdata = '0;
		endcase
	end

	logic restart_cfg;
	assign restart_cfg = cfg_wr & ((cfg_sel == REG_FRAME_WIDTH) | (cfg_sel == REG_FRAME_HEIGHT));

	// clamped frame size
	logic [WW-1:0]       eff_w;
	logic [HEIGHT_W-1:0] eff_h;

	always_comb begin
		if (frame_width_q == '0)
			eff_w = WW'(1);
		else if (32'(frame_width_q) > 32'(MAX_WIDTH))
			eff_w = WW'(MAX_WIDTH);
		else
			eff_w = WW'(frame_width_q);
		if (frame_height_q == '0)
			eff_h = HEIGHT_W'(1);
		else if (32'(frame_height_q) > 32'(MAX_HEIGHT))
			eff_h = HEIGHT_W'(MAX_HEIGHT);
		else
			eff_h = frame_height_q;
	end

	// stream counters
	logic [CW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic             in_done_q;
	logic [FW-1:0]    fill_q;
	logic [CW-1:0]    out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic             accept;
	logic             proc;
	logic [WW:0]      in_col_inc;
	logic             in_wrap;
	logic             in_row_last;
	logic             res_now;
	logic [WW:0]      out_col_inc;
	logic             out_row_last;
	win_ctl_t         ctl_now;

	assign accept       = s_axis_tvalid & s_axis_tready;
	assign proc         = accept & (in_done_q | (opcode_t'(s_axis_tuser) == OP_PIXEL));
	assign in_col_inc   = (WW+1)'(in_col_q) + (WW+1)'(1);
	assign in_wrap      = in_col_inc >= (WW+1)'(eff_w);
	assign in_row_last  = ((HEIGHT_W)'(in_row_q) + HEIGHT_W'(1)) >= eff_h;
	assign res_now      = fill_q >= (FW'(eff_w) + FW'(1));
	assign out_col_inc  = (WW+1)'(out_col_q) + (WW+1)'(1);
	assign out_row_last = ((HEIGHT_W)'(out_row_q) + HEIGHT_W'(1)) >= eff_h;

	always_comb begin
		ctl_now.line_end   = out_col_inc >= (WW+1)'(eff_w);
		ctl_now.frame_end  = ctl_now.line_end & out_row_last;
		ctl_now.left_out   = out_col_q == '0;
		ctl_now.right_out  = ctl_now.line_end;
		ctl_now.top_out    = out_row_q == '0;
		ctl_now.bottom_out = out_row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			fill_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart_cfg || (proc && res_now && ctl_now.frame_end)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			fill_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (proc) begin
			if (in_wrap) begin
				in_col_q <= '0;
				if (!in_done_q) begin
					if (in_row_last) begin
						in_row_q  <= '0;
						in_done_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + ROW_W'(1);
					end
				end
			end else begin
				in_col_q <= CW'(in_col_inc);
			end
			if (!res_now) begin
				fill_q <= fill_q + FW'(1);
			end else if (ctl_now.line_end) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + ROW_W'(1);
			end else begin
				out_col_q <= CW'(out_col_inc);
			end
		end
	end

	// stage 1: line store read, bypass of the write still in flight
	pixel_t   upper_mem_q [MAX_WIDTH];
	pixel_t   middle_mem_q [MAX_WIDTH];
	pixel_t   up_rd_q;
	pixel_t   mid_rd_q;
	logic     v_s1;
	logic     res_s1;
	logic     byp_s1;
	pixel_t   pix_s1;
	pixel_t   byp_up_s1;
	pixel_t   byp_mid_s1;
	logic [CW-1:0] col_s1;
	win_ctl_t ctl_s1;
	pixel_t   up_s1;
	pixel_t   mid_s1;

	assign up_s1  = byp_s1 ? byp_up_s1  : up_rd_q;
	assign mid_s1 = byp_s1 ? byp_mid_s1 : mid_rd_q;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			upper_mem_q[col_s1]  <= mid_s1;
			middle_mem_q[col_s1] <= pix_s1;
		end
		up_rd_q  <= upper_mem_q[in_col_q];
		mid_rd_q <= middle_mem_q[in_col_q];
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			pix_s1     <= in_done_q ? '0 : s_axis_tdata;
			col_s1     <= in_col_q;
			ctl_s1     <= ctl_now;
			byp_s1     <= v_s1 && (col_s1 == in_col_q);
			byp_up_s1  <= mid_s1;
			byp_mid_s1 <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			res_s1 <= 1'b0;
		end else begin
			v_s1   <= proc;
			res_s1 <= proc & res_now;
		end
	end

	// stage 2: window shift, then edge test on the shifted window
	pixel_t   win_q [3][3];
	logic     res_s2;
	win_ctl_t ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					win_q[c][r] <= '0;
		end else if (v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[0][r] <= win_q[1][r];
				win_q[1][r] <= win_q[2][r];
			end
			win_q[2][0] <= up_s1;
			win_q[2][1] <= mid_s1;
			win_q[2][2] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1)
			ctl_s2 <= ctl_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_s2 <= 1'b0;
		else
			res_s2 <= res_s1;
	end

	logic edge_bit;

	always_comb begin
		edge_bit = 1'b0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (!(c == 1 && r == 1) &&
				    !(c == 0 && ctl_s2.left_out) && !(c == 2 && ctl_s2.right_out) &&
				    !(r == 0 && ctl_s2.top_out) && !(r == 2 && ctl_s2.bottom_out) &&
				    chan_exceeds(win_q[c][r], win_q[1][1], edge_threshold_q))
					edge_bit = 1'b1;
			end
		end
	end

	// output queue
	result_t       fifo_q [OUT_FIFO_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   cnt_q;
	logic          push;
	logic          pop;
	logic [QW+1:0] pending;
	result_t       head;

	assign push    = res_s2;
	assign pop     = m_axis_tvalid & m_axis_tready;
	assign pending = (QW+2)'(cnt_q) + (QW+2)'(res_s1) + (QW+2)'(res_s2);
	assign s_axis_tready = pending < (QW+2)'(OUT_FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].edge_res  <= edge_bit;
			fifo_q[wr_ptr_q].line_end  <= ctl_s2.line_end;
			fifo_q[wr_ptr_q].frame_end <= ctl_s2.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QW+1)'(1);
		end
	end

	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = {7'b0, head.edge_res};
	assign m_axis_tlast  = head.line_end;
	assign m_axis_tuser  = head.frame_end;

endmodule
